/* design/fourier_series_evaluator_unit_defines.svh */
// Assertion macros shared by the Fourier series evaluator RTL
`ifndef FOURIER_SERIES_EVALUATOR_UNIT_DEFINES_SVH
`define FOURIER_SERIES_EVALUATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define FSE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition is followed by a consequence in the next cycle.
`define FSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define FSE_ASSERT(label, prop, msg)
`define FSE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* design/fse_pkg.sv */
// Shared types, constants and helpers of the Fourier series evaluator
`timescale 1ns / 1ps
`default_nettype none

package fse_pkg;

    typedef enum logic [1:0] {
        CMD_WR_COS = 2'd0,
        CMD_WR_SIN = 2'd1,
        CMD_EVAL   = 2'd2
    } cmd_t;

    // Micro-steps of one harmonic term; each is one pass through the multiplier.
    typedef logic [3:0] step_t;
    localparam step_t STEP_ANGLE   = 4'd0;
    localparam step_t STEP_SQUARE  = 4'd1;
    localparam step_t STEP_S_DIV42 = 4'd2;
    localparam step_t STEP_S_MUL1  = 4'd3;
    localparam step_t STEP_S_DIV20 = 4'd4;
    localparam step_t STEP_S_MUL2  = 4'd5;
    localparam step_t STEP_S_DIV6  = 4'd6;
    localparam step_t STEP_S_FIN   = 4'd7;
    localparam step_t STEP_C_DIV56 = 4'd8;
    localparam step_t STEP_C_MUL1  = 4'd9;
    localparam step_t STEP_C_DIV30 = 4'd10;
    localparam step_t STEP_C_MUL2  = 4'd11;
    localparam step_t STEP_C_DIV12 = 4'd12;
    localparam step_t STEP_C_FIN   = 4'd13;
    localparam step_t STEP_ACC_COS = 4'd14;
    localparam step_t STEP_ACC_SIN = 4'd15;

    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [29:0] HALF_OCT = 30'h2000_0000;

    // Exact floor division of values below 2^30: q = (v * M) >> S,
    // with S = 30 + ceil(log2 d) and M = ceil(2^S / d).
    localparam int DIV42_S = 36;
    localparam int DIV20_S = 35;
    localparam int DIV6_S  = 33;
    localparam int DIV56_S = 36;
    localparam int DIV30_S = 35;
    localparam int DIV12_S = 34;
    localparam logic [31:0] DIV42_M = 32'(((64'd1 << DIV42_S) + 64'd41) / 64'd42);
    localparam logic [31:0] DIV20_M = 32'(((64'd1 << DIV20_S) + 64'd19) / 64'd20);
    localparam logic [31:0] DIV6_M  = 32'(((64'd1 << DIV6_S) + 64'd5) / 64'd6);
    localparam logic [31:0] DIV56_M = 32'(((64'd1 << DIV56_S) + 64'd55) / 64'd56);
    localparam logic [31:0] DIV30_M = 32'(((64'd1 << DIV30_S) + 64'd29) / 64'd30);
    localparam logic [31:0] DIV12_M = 32'(((64'd1 << DIV12_S) + 64'd11) / 64'd12);

    // Round a Q2.30 magnitude to Q1.15 and clip at the largest positive code.
    function automatic logic [14:0] to_q15(input logic [30:0] v);
        logic [16:0] q;
        q = 17'((32'(v) + 32'd16384) >> 15);
        return (q > 17'd32767) ? 15'h7FFF : q[14:0];
    endfunction

endpackage

`default_nettype wire

/* design/fse_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module fse_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/fourier_series_evaluator_unit.sv */
// Fourier series evaluator: coefficient tables, term sequencer and shared multiplier
//
// Request channel (req_valid/req_ready) carries cmd, coeff_index, coeff_value, phase.
//   Write requests (cosine or sine coefficient) finish in the cycle they are taken.
//   An evaluate request yields one series_value on the result channel
//   (result_valid/result_ready); writes and unknown commands yield nothing.
// An evaluate request runs a0 and then N harmonic terms, N = term_count clipped
//   to MAX_TERMS. Each harmonic term takes one phase setup state plus sixteen
//   passes through the single 33x33 multiplier, each a product state and then
//   a write-back state; every step of a term shares that one multiplier.
// req_ready is high whenever no evaluation runs, also while a result waits.
// A finished result that meets a stalled receiver holds the sequencer until
//   the output register frees up; nothing is dropped.
// term_count sits at APB byte address 0; write it only while idle.
// Reset clears term_count, the sequencer and the result valid flag; the
//   coefficient tables hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none
`include "fourier_series_evaluator_unit_defines.svh"

module fourier_series_evaluator_unit
    import fse_pkg::*;
#(
    parameter int MAX_TERMS  = 64,
    parameter int PHASE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [1:0]                         cmd,
    input  logic [$clog2(MAX_TERMS + 1)-1:0]   coeff_index,
    input  logic signed [23:0]                 coeff_value,
    input  logic [PHASE_BITS-1:0]              phase,
    // result channel
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [31:0]                 series_value,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int IDX_W  = $clog2(MAX_TERMS + 1);
    localparam int SIN_AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int ACC_W  = 48 + IDX_W;
    localparam int RND_W  = ACC_W - 15;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(16384);
    localparam logic signed [RND_W-1:0] RES_MAX  = RND_W'(64'sd2147483647);
    localparam logic signed [RND_W-1:0] RES_MIN  = RND_W'(-64'sd2147483648);
    localparam logic [IDX_W-1:0]        TERM_MAX = IDX_W'(MAX_TERMS);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_START = 8'b0000_0010,
        ST_A0    = 8'b0000_0100,
        ST_PREP  = 8'b0000_1000,
        ST_MUL   = 8'b0001_0000,
        ST_WB    = 8'b0010_0000,
        ST_FIN   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    // Control state
    state_t              state_reg, state_next;
    step_t               step_reg, step_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]    n_reg, n_next;
    logic [IDX_W-1:0]    term_count_reg;
    logic                result_valid_reg, result_valid_next;

    // Datapath
    logic [PHASE_BITS-1:0] x_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [2:0]            oct_reg;
    logic [29:0]           r_reg;
    logic [29:0]           t_reg;
    logic [29:0]           t2_reg;
    logic [29:0]           u_reg;
    logic [30:0]           h_reg;
    logic [14:0]           s_reg;
    logic signed [15:0]    so_reg;
    logic signed [15:0]    co_reg;
    logic signed [65:0]    prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [RND_W-1:0] round_reg;
    logic signed [31:0]    result_reg;

    logic                  req_take;
    logic                  reg_sel;
    logic                  cfg_write;
    logic                  out_free;
    logic                  cos_we;
    logic                  sin_we;
    logic [SIN_AW-1:0]     sin_waddr;
    logic [SIN_AW-1:0]     sin_raddr;
    logic signed [23:0]    cos_rd;
    logic signed [23:0]    sin_rd;
    logic signed [32:0]    mul_a;
    logic signed [32:0]    mul_b;
    logic [31:0]           turn;
    logic [14:0]           cos_q15;
    logic                  swap;
    logic [14:0]           so_mag;
    logic [14:0]           co_mag;

    // ------------------------------------------------------------------
    // Configuration port: one register, zero wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = (paddr == 3'd0);
    assign cfg_write = psel && penable && pwrite && reg_sel;
    assign prdata    = reg_sel ? 32'(term_count_reg) : 32'd0;

    // ------------------------------------------------------------------
    // Request intake and coefficient tables
    // ------------------------------------------------------------------
    assign req_ready = (state_reg == ST_IDLE);
    assign req_take  = req_valid && req_ready;

    // Drop writes to indexes outside the tables; sine harmonics start at 1.
    assign cos_we    = req_take && (cmd == CMD_WR_COS) && (coeff_index <= TERM_MAX);
    assign sin_we    = req_take && (cmd == CMD_WR_SIN) && (coeff_index != '0)
                       && (coeff_index <= TERM_MAX);
    assign sin_waddr = SIN_AW'(coeff_index - IDX_W'(1));
    assign sin_raddr = (k_reg == '0) ? '0 : SIN_AW'(k_reg - IDX_W'(1));

    fse_ram #(
        .WIDTH (24),
        .DEPTH (MAX_TERMS + 1)
    ) u_cos_ram (
        .clk     (clk),
        .wr_en   (cos_we),
        .wr_addr (coeff_index),
        .wr_data (coeff_value),
        .rd_addr (k_reg),
        .rd_data (cos_rd)
    );

    fse_ram #(
        .WIDTH (24),
        .DEPTH (MAX_TERMS)
    ) u_sin_ram (
        .clk     (clk),
        .wr_en   (sin_we),
        .wr_addr (sin_waddr),
        .wr_data (coeff_value),
        .rd_addr (sin_raddr),
        .rd_data (sin_rd)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        k_next            = k_reg;
        n_next            = n_reg;
        result_valid_next = result_valid_reg;

        if (result_valid_reg && result_ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_take && (cmd == CMD_EVAL))
                begin
                    // Latch the term limit and point the cosine read at a0.
                    k_next     = '0;
                    n_next     = (term_count_reg > TERM_MAX) ? TERM_MAX : term_count_reg;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_A0;
            end
            ST_A0:
            begin
                k_next     = IDX_W'(1);
                state_next = (n_reg == '0) ? ST_FIN : ST_PREP;
            end
            ST_PREP:
            begin
                step_next  = STEP_ANGLE;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (step_reg == STEP_ACC_SIN)
                begin
                    if (k_reg == n_reg)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_PREP;
                    end
                end
                else
                begin
                    step_next  = step_reg + step_t'(1);
                    state_next = ST_MUL;
                end
            end
            ST_FIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold here until the output register can take the result.
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= STEP_ANGLE;
            k_reg            <= '0;
            n_reg            <= '0;
            term_count_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            k_reg            <= k_next;
            n_reg            <= n_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                term_count_reg <= pwdata[IDX_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand select
    // ------------------------------------------------------------------
    always_comb
    begin
        case (step_reg)
            STEP_ANGLE:
            begin
                mul_a = 33'(r_reg);
                mul_b = 33'(PI_Q30);
            end
            STEP_SQUARE:
            begin
                mul_a = 33'(t_reg);
                mul_b = 33'(t_reg);
            end
            STEP_S_DIV42:
            begin
                mul_a = 33'(t2_reg);
                mul_b = 33'(DIV42_M);
            end
            STEP_S_DIV20:
            begin
                mul_a = 33'(u_reg);
                mul_b = 33'(DIV20_M);
            end
            STEP_S_DIV6:
            begin
                mul_a = 33'(u_reg);
                mul_b = 33'(DIV6_M);
            end
            STEP_C_DIV56:
            begin
                mul_a = 33'(t2_reg);
                mul_b = 33'(DIV56_M);
            end
            STEP_C_DIV30:
            begin
                mul_a = 33'(u_reg);
                mul_b = 33'(DIV30_M);
            end
            STEP_C_DIV12:
            begin
                mul_a = 33'(u_reg);
                mul_b = 33'(DIV12_M);
            end
            STEP_S_MUL1, STEP_S_MUL2, STEP_C_MUL1, STEP_C_MUL2, STEP_C_FIN:
            begin
                mul_a = 33'(t2_reg);
                mul_b = 33'(h_reg);
            end
            STEP_S_FIN:
            begin
                mul_a = 33'(t_reg);
                mul_b = 33'(h_reg);
            end
            STEP_ACC_COS:
            begin
                mul_a = 33'(cos_rd);
                mul_b = 33'(co_reg);
            end
            STEP_ACC_SIN:
            begin
                mul_a = 33'(sin_rd);
                mul_b = 33'(so_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Octant folding and sign restore
    // ------------------------------------------------------------------
    // Scale the harmonic phase to a full 32-bit turn.
    assign turn = 32'(phase_reg) << (32 - PHASE_BITS);

    // Last cosine step: b = 1 - (t2*b >> 30) / 2, then round to Q1.15.
    assign cos_q15 = to_q15(Q30_ONE - 31'(prod_reg[60:31]));

    // Octants 1, 2, 5 and 6 trade sine and cosine.
    assign swap   = oct_reg[1] ^ oct_reg[0];
    assign so_mag = swap ? cos_q15 : s_reg;
    assign co_mag = swap ? s_reg : cos_q15;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (req_take && (cmd == CMD_EVAL))
        begin
            x_reg <= phase;
        end

        case (state_reg)
            ST_A0:
            begin
                // Start from a0/2 in the Q.31 accumulator scale.
                acc_reg   <= ACC_W'(cos_rd) <<< 14;
                phase_reg <= x_reg;
            end
            ST_PREP:
            begin
                // Fold the turn into the first octant; mirror odd octants.
                oct_reg   <= turn[31:29];
                r_reg     <= turn[29] ? (HALF_OCT - 30'(turn[28:0])) : 30'(turn[28:0]);
                phase_reg <= phase_reg + x_reg;
            end
            ST_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            ST_WB:
            begin
                case (step_reg)
                    STEP_ANGLE:   t_reg  <= prod_reg[60:31];
                    STEP_SQUARE:  t2_reg <= prod_reg[59:30];
                    STEP_S_DIV42: h_reg  <= Q30_ONE - 31'(prod_reg[DIV42_S +: 30]);
                    STEP_S_DIV20: h_reg  <= Q30_ONE - 31'(prod_reg[DIV20_S +: 30]);
                    STEP_S_DIV6:  h_reg  <= Q30_ONE - 31'(prod_reg[DIV6_S +: 30]);
                    STEP_C_DIV56: h_reg  <= Q30_ONE - 31'(prod_reg[DIV56_S +: 30]);
                    STEP_C_DIV30: h_reg  <= Q30_ONE - 31'(prod_reg[DIV30_S +: 30]);
                    STEP_C_DIV12: h_reg  <= Q30_ONE - 31'(prod_reg[DIV12_S +: 30]);
                    STEP_S_MUL1, STEP_S_MUL2, STEP_C_MUL1, STEP_C_MUL2:
                    begin
                        u_reg <= prod_reg[59:30];
                    end
                    STEP_S_FIN:
                    begin
                        s_reg <= to_q15(31'(prod_reg[59:30]));
                    end
                    STEP_C_FIN:
                    begin
                        // Sine negative in the lower half turn, cosine in octants 2..5.
                        so_reg <= oct_reg[2] ? -16'(so_mag) : 16'(so_mag);
                        co_reg <= (oct_reg[2] ^ oct_reg[1]) ? -16'(co_mag) : 16'(co_mag);
                    end
                    STEP_ACC_COS, STEP_ACC_SIN:
                    begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                    default:
                    begin
                        t_reg <= t_reg;
                    end
                endcase
            end
            ST_FIN:
            begin
                // Round Q.31 to Q.16: add half an LSB, then floor.
                round_reg <= RND_W'((acc_reg + RND_HALF) >>> 15);
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    if (round_reg > RES_MAX)
                    begin
                        result_reg <= 32'sh7FFF_FFFF;
                    end
                    else if (round_reg < RES_MIN)
                    begin
                        result_reg <= 32'sh8000_0000;
                    end
                    else
                    begin
                        result_reg <= 32'(round_reg);
                    end
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign series_value = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FSE_ASSERT(a_result_from_out, $rose(result_valid_reg) |-> $past(state_reg == ST_OUT), "result raised outside the output state")
    `FSE_ASSERT_NEXT(a_out_holds, (state_reg == ST_OUT) && result_valid_reg && !result_ready, (state_reg == ST_OUT), "sequencer left the output state while the result register was full")
    `FSE_ASSERT(a_term_range, (state_reg == ST_WB) |-> ((k_reg != '0) && (k_reg <= n_reg)), "harmonic index out of range during a term")
    `FSE_ASSERT_NEXT(a_term_start, (state_reg == ST_PREP), ((state_reg == ST_MUL) && (step_reg == STEP_ANGLE)), "term did not start at the angle step")

endmodule

`default_nettype wire
